// ===== design/hfnc_pkg.sv =====
package hfnc_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [0:0] CFG_SPACING_X = 1'b0;
    localparam logic [0:0] CFG_SPACING_Y = 1'b1;

    localparam logic [1:0] OP_CENTRAL  = 2'd0;
    localparam logic [1:0] OP_FORWARD  = 2'd1;
    localparam logic [1:0] OP_BACKWARD = 2'd2;

    localparam int D1_STEPS = 31;
    localparam int D2_STEPS = 61;
    localparam int RT_STEPS = 32;
    localparam int D3_STEPS = 63;
    localparam int D4_STEPS = 31;
    localparam int D4W      = 62 - FRAC_BITS;

    localparam int S_K   = 0;
    localparam int S_P1  = S_K + 1;
    localparam int S_D1  = S_P1 + 1;
    localparam int S_R1  = S_D1 + D1_STEPS + 1;
    localparam int S_SQ  = S_R1 + 1;
    localparam int S_D2  = S_SQ + 1;
    localparam int S_PQ  = S_D2 + D2_STEPS + 1;
    localparam int S_RT  = S_PQ + 1;
    localparam int S_C3P = S_RT + RT_STEPS + 1;
    localparam int S_C3  = S_C3P + 1;
    localparam int S_P2  = S_C3 + 1;
    localparam int S_D3  = S_P2 + 1;
    localparam int S_R3  = S_D3 + D3_STEPS + 1;
    localparam int S_P3P = S_R3 + 1;
    localparam int S_P3  = S_P3P + 1;
    localparam int S_D4  = S_P3 + 1;
    localparam int S_OUT = S_D4 + D4_STEPS + 1;

    typedef struct packed {
        logic [1:0]         op;
        logic               vertical;
        logic               sign_negative;
        logic signed [31:0] height_a;
        logic signed [31:0] height_b;
        logic signed [31:0] height_c;
        logic [19:0]        cell_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] curvature;
        logic               saturated;
        logic [19:0]        cell_tag;
    } t_out_item;

    typedef struct packed {
        logic [19:0] tag;
        logic        vert;
        logic        neg;
        logic        k1neg;
        logic        k2pos;
        logic        sat;
        logic [33:0] m2;
        logic [31:0] num;
        logic [31:0] den;
        logic [30:0] npar;
        logic [30:0] nperp;
        logic [30:0] c3;
    } t_side;

endpackage

// ===== design/height_function_normal_curvature_unit.sv =====
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Depth is set by the restoring dividers and square roots, one quotient or root bit a stage.
// Reset (synchronous, active low) clears all valid bits and sets both spacings to 1.0.
module height_function_normal_curvature_unit import hfnc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out
);

    logic [31:0] r_spacing_x, r_spacing_y;
    logic        r_vld [0:S_OUT];
    t_side       r_side [0:S_OUT-1];
    t_out_item   r_out;
    logic        adv;

    logic [34:0] r_m1;
    logic [66:0] r_p1;
    logic [32:0] r_d1_rem [0:D1_STEPS];
    logic [30:0] r_d1_low [0:D1_STEPS];
    logic [30:0] r_d1_q   [0:D1_STEPS];
    logic        r_d1_ovf [0:D1_STEPS];
    logic [30:0] r_dm;
    logic [61:0] r_d2;
    logic [62:0] r_d2_rem [0:D2_STEPS];
    logic [62:0] r_d2_w   [0:D2_STEPS];
    logic [60:0] r_d2_q   [0:D2_STEPS];
    logic [60:0] r_pq_p, r_pq_q;
    logic [63:0] r_rt_v [0:1][0:RT_STEPS];
    logic [63:0] r_rt_r [0:1][0:RT_STEPS];
    logic [60:0] r_rt_p [0:RT_STEPS];
    logic [62:0] r_c3_lo;
    logic [59:0] r_c3_hi;
    logic [65:0] r_p2;
    logic [31:0] r_d3_rem [0:D3_STEPS];
    logic [62:0] r_d3_low [0:D3_STEPS];
    logic [62:0] r_d3_q   [0:D3_STEPS];
    logic        r_d3_ovf [0:D3_STEPS];
    logic [62:0] r_x;
    logic [61:0] r_p3_hi;
    logic [62:0] r_p3_lo;
    logic [92:0] r_p3;
    logic [D4W-1:0] r_d4_rem [0:D4_STEPS];
    logic [30:0]    r_d4_low [0:D4_STEPS];
    logic [30:0]    r_d4_q   [0:D4_STEPS];
    logic           r_d4_ovf [0:D4_STEPS];

    t_side              n_side;
    t_side              n_shift [1:S_OUT-1];
    logic signed [35:0] n_ea, n_eb, n_ec, n_k1, n_k2;
    logic [34:0]        n_m1;
    logic [31:0]        n_sx, n_sy;

    logic [33:0] n_d1_t [1:D1_STEPS];
    logic [33:0] n_d1_d [1:D1_STEPS];
    logic        n_d1_ge [1:D1_STEPS];
    logic [32:0] n_r1_d;
    logic        n_r1_up;
    logic [31:0] n_r1_q;
    logic        n_r1_clip;

    logic [63:0] n_d2_t [1:D2_STEPS];
    logic        n_d2_ge [1:D2_STEPS];
    logic [62:0] n_pq_h;

    logic [63:0] n_rt_b [1:RT_STEPS];
    logic [63:0] n_rt_t [0:1][1:RT_STEPS];
    logic        n_rt_ge [0:1][1:RT_STEPS];
    logic [91:0] n_c3_sum;

    logic [32:0] n_d3_t [1:D3_STEPS];
    logic [32:0] n_d3_d [1:D3_STEPS];
    logic        n_d3_ge [1:D3_STEPS];
    logic        n_r3_up;
    logic [63:0] n_r3_q;
    logic        n_r3_clip;

    logic [D4W:0]   n_d4_t [1:D4_STEPS];
    logic [D4W:0]   n_d4_d [1:D4_STEPS];
    logic           n_d4_ge [1:D4_STEPS];
    logic [D4W-1:0] n_r4_d;
    logic           n_r4_up;
    logic [31:0]    n_r4_q;
    logic           n_r4_clip;
    logic [30:0]    n_r4_km;

    assign adv         = !r_vld[S_OUT] || i_out_ready;
    assign o_in_ready  = adv;
    assign o_out_valid = r_vld[S_OUT];
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing_x <= 32'(64'd1 << FRAC_BITS);
            r_spacing_y <= 32'(64'd1 << FRAC_BITS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPACING_X: r_spacing_x <= i_cfg_data;
                CFG_SPACING_Y: r_spacing_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= S_OUT; s++) r_vld[s] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s <= S_OUT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_comb begin
        n_ea = 36'(i_in.height_a);
        n_eb = 36'(i_in.height_b);
        n_ec = 36'(i_in.height_c);
        case (i_in.op)
            OP_FORWARD:  n_k1 = (n_eb <<< 2) - n_ea - (n_ea <<< 1) - n_ec;
            OP_BACKWARD: n_k1 = n_ea - (n_eb <<< 2) + n_ec + (n_ec <<< 1);
            default:     n_k1 = n_ec - n_ea;
        endcase
        n_k2 = n_ea - (n_eb <<< 1) + n_ec;
        n_m1 = n_k1[35] ? 35'(-n_k1) : n_k1[34:0];
        n_sx = (r_spacing_x == '0) ? 32'd1 : r_spacing_x;
        n_sy = (r_spacing_y == '0) ? 32'd1 : r_spacing_y;
        n_side       = '0;
        n_side.tag   = i_in.cell_index;
        n_side.vert  = i_in.vertical;
        n_side.neg   = i_in.sign_negative;
        n_side.k1neg = n_k1[35];
        n_side.k2pos = !n_k2[35] && (n_k2 != '0);
        n_side.m2    = n_k2[35] ? 34'(-n_k2) : n_k2[33:0];
        n_side.num   = i_in.vertical ? n_sy : n_sx;
        n_side.den   = i_in.vertical ? n_sx : n_sy;
    end

    always_comb begin
        for (int j = 1; j <= D1_STEPS; j++) begin
            n_d1_t[j]  = {r_d1_rem[j-1], r_d1_low[j-1][30]};
            n_d1_d[j]  = {1'b0, r_side[S_D1+j-1].den, 1'b0};
            n_d1_ge[j] = n_d1_t[j] >= n_d1_d[j];
        end
        n_r1_d    = {r_side[S_R1-1].den, 1'b0};
        n_r1_up   = r_d1_rem[D1_STEPS] >= (n_r1_d - r_d1_rem[D1_STEPS]);
        n_r1_q    = {1'b0, r_d1_q[D1_STEPS]} + 32'(n_r1_up);
        n_r1_clip = r_d1_ovf[D1_STEPS] || n_r1_q[31];

        for (int j = 1; j <= D2_STEPS; j++) begin
            n_d2_t[j]  = {r_d2_rem[j-1], 1'b0};
            n_d2_ge[j] = n_d2_t[j] >= {1'b0, r_d2_w[j-1]};
        end
        n_pq_h = r_d2_w[D2_STEPS] - r_d2_rem[D2_STEPS];

        for (int j = 1; j <= RT_STEPS; j++) begin
            n_rt_b[j] = 64'd1 << (64 - 2 * j);
            for (int l = 0; l < 2; l++) begin
                n_rt_t[l][j]  = r_rt_r[l][j-1] + n_rt_b[j];
                n_rt_ge[l][j] = r_rt_v[l][j-1] >= n_rt_t[l][j];
            end
        end
        n_c3_sum = {r_c3_hi, 32'd0} + {29'd0, r_c3_lo} + (92'd1 << 59);

        for (int j = 1; j <= D3_STEPS; j++) begin
            n_d3_t[j]  = {r_d3_rem[j-1], r_d3_low[j-1][62]};
            n_d3_d[j]  = {1'b0, r_side[S_D3+j-1].den};
            n_d3_ge[j] = n_d3_t[j] >= n_d3_d[j];
        end
        n_r3_up   = r_d3_rem[D3_STEPS] >= (r_side[S_R3-1].den - r_d3_rem[D3_STEPS]);
        n_r3_q    = {1'b0, r_d3_q[D3_STEPS]} + 64'(n_r3_up);
        n_r3_clip = r_d3_ovf[D3_STEPS] || (n_r3_q > (64'd1 << 62));

        for (int j = 1; j <= D4_STEPS; j++) begin
            n_d4_t[j]  = {r_d4_rem[j-1], r_d4_low[j-1][30]};
            n_d4_d[j]  = {1'b0, r_side[S_D4+j-1].den, {(30-FRAC_BITS){1'b0}}};
            n_d4_ge[j] = n_d4_t[j] >= n_d4_d[j];
        end
        n_r4_d    = {r_side[S_OUT-1].den, {(30-FRAC_BITS){1'b0}}};
        n_r4_up   = r_d4_rem[D4_STEPS] >= (n_r4_d - r_d4_rem[D4_STEPS]);
        n_r4_q    = {1'b0, r_d4_q[D4_STEPS]} + 32'(n_r4_up);
        n_r4_clip = r_d4_ovf[D4_STEPS] || n_r4_q[31];
        n_r4_km   = n_r4_clip ? 31'h7FFF_FFFF : n_r4_q[30:0];

        for (int s = 1; s < S_OUT; s++) n_shift[s] = r_side[s-1];
        n_shift[S_R1].sat    = n_r1_clip;
        n_shift[S_C3P].npar  = r_rt_r[0][RT_STEPS][30:0];
        n_shift[S_C3P].nperp = r_rt_r[1][RT_STEPS][30:0];
        n_shift[S_C3].c3     = n_c3_sum[90:60];
        n_shift[S_R3].sat    = r_side[S_R3-1].sat || n_r3_clip;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[S_K] <= n_side;
            r_m1        <= n_m1;
            for (int s = 1; s < S_OUT; s++) r_side[s] <= n_shift[s];

            r_p1 <= {32'd0, r_m1} * {35'd0, r_side[S_K].num};

            r_d1_ovf[0] <= r_p1[66:31] >= {3'd0, r_side[S_P1].den, 1'b0};
            r_d1_rem[0] <= r_p1[63:31];
            r_d1_low[0] <= r_p1[30:0];
            r_d1_q[0]   <= '0;
            for (int j = 1; j <= D1_STEPS; j++) begin
                r_d1_rem[j] <= n_d1_ge[j] ? 33'(n_d1_t[j] - n_d1_d[j]) : n_d1_t[j][32:0];
                r_d1_low[j] <= r_d1_low[j-1] << 1;
                r_d1_q[j]   <= {r_d1_q[j-1][29:0], n_d1_ge[j]};
                r_d1_ovf[j] <= r_d1_ovf[j-1];
            end
            r_dm <= n_r1_clip ? 31'h7FFF_FFFF : n_r1_q[30:0];

            r_d2 <= {31'd0, r_dm} * {31'd0, r_dm};

            r_d2_w[0]   <= (63'd1 << (2 * FRAC_BITS)) + {1'b0, r_d2};
            r_d2_rem[0] <= 63'd1 << (2 * FRAC_BITS - 1);
            r_d2_q[0]   <= '0;
            for (int j = 1; j <= D2_STEPS; j++) begin
                r_d2_rem[j] <= n_d2_ge[j] ? 63'(n_d2_t[j] - {1'b0, r_d2_w[j-1]})
                                          : n_d2_t[j][62:0];
                r_d2_w[j]   <= r_d2_w[j-1];
                r_d2_q[j]   <= {r_d2_q[j-1][59:0], n_d2_ge[j]};
            end

            r_pq_p <= r_d2_q[D2_STEPS] + 61'(r_d2_rem[D2_STEPS] >= n_pq_h);
            r_pq_q <= ((61'd1 << 60) + 61'(n_pq_h >= r_d2_rem[D2_STEPS]))
                      - (r_d2_q[D2_STEPS] + 61'd1);

            r_rt_v[0][0] <= {3'd0, r_pq_p};
            r_rt_v[1][0] <= {3'd0, r_pq_q};
            r_rt_r[0][0] <= '0;
            r_rt_r[1][0] <= '0;
            r_rt_p[0]    <= r_pq_p;
            for (int j = 1; j <= RT_STEPS; j++) begin
                for (int l = 0; l < 2; l++) begin
                    r_rt_v[l][j] <= n_rt_ge[l][j] ? r_rt_v[l][j-1] - n_rt_t[l][j]
                                                  : r_rt_v[l][j-1];
                    r_rt_r[l][j] <= n_rt_ge[l][j] ? (r_rt_r[l][j-1] >> 1) + n_rt_b[j]
                                                  : r_rt_r[l][j-1] >> 1;
                end
                r_rt_p[j] <= r_rt_p[j-1];
            end

            r_c3_lo <= {31'd0, r_rt_p[RT_STEPS][31:0]} * {32'd0, r_rt_r[0][RT_STEPS][30:0]};
            r_c3_hi <= {31'd0, r_rt_p[RT_STEPS][60:32]} * {29'd0, r_rt_r[0][RT_STEPS][30:0]};

            r_p2 <= {32'd0, r_side[S_C3].m2} * {34'd0, r_side[S_C3].num};

            r_d3_ovf[0] <= {29'd0, r_p2[65:63]} >= r_side[S_P2].den;
            r_d3_rem[0] <= {29'd0, r_p2[65:63]};
            r_d3_low[0] <= r_p2[62:0];
            r_d3_q[0]   <= '0;
            for (int j = 1; j <= D3_STEPS; j++) begin
                r_d3_rem[j] <= n_d3_ge[j] ? 32'(n_d3_t[j] - n_d3_d[j]) : n_d3_t[j][31:0];
                r_d3_low[j] <= r_d3_low[j-1] << 1;
                r_d3_q[j]   <= {r_d3_q[j-1][61:0], n_d3_ge[j]};
                r_d3_ovf[j] <= r_d3_ovf[j-1];
            end
            r_x <= n_r3_clip ? (63'd1 << 62) : n_r3_q[62:0];

            r_p3_hi <= {31'd0, r_x[62:32]} * {31'd0, r_side[S_R3].c3};
            r_p3_lo <= {31'd0, r_x[31:0]} * {32'd0, r_side[S_R3].c3};

            r_p3 <= 93'({r_p3_hi, 32'd0} + {31'd0, r_p3_lo});

            r_d4_ovf[0] <= r_p3[92:31] >= 62'({r_side[S_P3].den, {(30-FRAC_BITS){1'b0}}});
            r_d4_rem[0] <= r_p3[31+D4W-1:31];
            r_d4_low[0] <= r_p3[30:0];
            r_d4_q[0]   <= '0;
            for (int j = 1; j <= D4_STEPS; j++) begin
                r_d4_rem[j] <= n_d4_ge[j] ? D4W'(n_d4_t[j] - n_d4_d[j])
                                          : n_d4_t[j][D4W-1:0];
                r_d4_low[j] <= r_d4_low[j-1] << 1;
                r_d4_q[j]   <= {r_d4_q[j-1][29:0], n_d4_ge[j]};
                r_d4_ovf[j] <= r_d4_ovf[j-1];
            end

            r_out.curvature <= r_side[S_OUT-1].k2pos ? -$signed({1'b0, n_r4_km})
                                                     : $signed({1'b0, n_r4_km});
            r_out.saturated <= r_side[S_OUT-1].sat || n_r4_clip;
            r_out.cell_tag  <= r_side[S_OUT-1].tag;
            if (r_side[S_OUT-1].vert) begin
                r_out.normal_x <= r_side[S_OUT-1].k1neg ? -$signed({1'b0, r_side[S_OUT-1].nperp})
                                                        : $signed({1'b0, r_side[S_OUT-1].nperp});
                r_out.normal_y <= r_side[S_OUT-1].neg ? -$signed({1'b0, r_side[S_OUT-1].npar})
                                                      : $signed({1'b0, r_side[S_OUT-1].npar});
            end else begin
                r_out.normal_x <= r_side[S_OUT-1].neg ? -$signed({1'b0, r_side[S_OUT-1].npar})
                                                      : $signed({1'b0, r_side[S_OUT-1].npar});
                r_out.normal_y <= r_side[S_OUT-1].k1neg ? -$signed({1'b0, r_side[S_OUT-1].nperp})
                                                        : $signed({1'b0, r_side[S_OUT-1].nperp});
            end
        end
    end

    a_nx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.normal_x <= 32'sd1073741824 && o_out.normal_x >= -32'sd1073741824))
        else $error("normal_x out of unit range");

    a_ny_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.normal_y <= 32'sd1073741824 && o_out.normal_y >= -32'sd1073741824))
        else $error("normal_y out of unit range");

    a_curv_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.curvature != 32'sh8000_0000))
        else $error("curvature reached negative full scale");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_vld[S_OUT]) && $stable(r_vld[S_D2]) && $stable(r_vld[S_D3])))
        else $error("pipeline moved during stall");

endmodule
